### rtl/hsvc_pkg.sv
// ============================================================================
// hsvc_pkg: shared types and constants for the HSV to RGBA converter
// Fixed-point formats, reciprocal constants and the stage payload structs.
// ============================================================================
`default_nettype none

package hsvc_pkg;

  // Channel format: 8-bit unsigned, full scale stands for 1.0
  localparam int CHAN_W = 8;
  localparam int CMAX   = (1 << CHAN_W) - 1;

  // Hue format: signed 1/16 degree units
  localparam int HUE_W      = 16;
  localparam int HUE_FRAC   = 4;
  localparam int HUE_SECT   = 60 << HUE_FRAC;     // one 60-degree sector
  localparam int HUE_FULL   = 360 << HUE_FRAC;    // one full turn
  localparam int HUE_BIAS   = 6 * HUE_FULL;       // whole turns, lifts hue above zero
  localparam int HUE_X_W    = HUE_W + 1;          // biased hue, unsigned
  localparam int SECT_SHIFT = 6;                  // HUE_SECT = 2^6 * 15
  localparam int HUE_Y_W    = HUE_X_W - SECT_SHIFT;
  localparam int QUOT_W     = 7;                  // sectors from zero, up to 70
  localparam int REM_W      = 10;                 // position inside a sector

  // Reciprocals, all exact over the operand ranges that reach them
  localparam int RCP15_W    = 13;
  localparam int RCP15      = 4370;               // x/15  = (x * 4370) >> 16
  localparam int RCP15_SH   = 16;
  localparam int RCP6_W     = 6;
  localparam int RCP6       = 43;                 // x/6   = (x * 43) >> 8
  localparam int RCP6_SH    = 8;

  // Term arithmetic
  localparam int DEN        = CMAX * HUE_SECT;    // 244800
  localparam int NUM_W      = 18;
  localparam int PROD_W     = NUM_W + CHAN_W;
  localparam int DEN_SHIFT  = 6;                  // DEN = 2^6 * 3825
  localparam int Z_W        = PROD_W - DEN_SHIFT;
  localparam int RCPD_W     = 21;
  localparam int RCPD       = 1122868;            // x/3825 = (x * RCPD) >> 32
  localparam int RCPD_SH    = 32;
  localparam int PP_W       = 2 * CHAN_W;
  localparam int RCPC_W     = 17;
  localparam int RCPC       = 65794;              // x/255  = (x * RCPC) >> 24
  localparam int RCPC_SH    = 24;

  typedef logic [CHAN_W-1:0] chan_t;

  // Hue sectors, named by the colors at their ends
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t          sector;
    logic [REM_W-1:0] rem;     // position inside the sector
    logic [REM_W-1:0] rem_c;   // distance to the sector end
    chan_t            sat;
    chan_t            bright;
  } sect_t;

  typedef struct packed {
    sector_t sector;
    chan_t   p;
    chan_t   q;
    chan_t   t;
    chan_t   bright;
  } terms_t;

endpackage

`default_nettype wire

### rtl/hsvc_in_if.sv
// ============================================================================
// hsvc_in_if: HSV input channel
// Valid/ready handshake carrying one HSV color per item.
// ============================================================================
`default_nettype none

interface hsvc_in_if;
  import hsvc_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [HUE_W-1:0] hue_sixteenths;
  chan_t             saturation;
  chan_t             brightness;

  modport source (
    output valid, hue_sixteenths, saturation, brightness,
    input  ready
  );

  modport sink (
    input  valid, hue_sixteenths, saturation, brightness,
    output ready
  );
endinterface

`default_nettype wire

### rtl/hsvc_out_if.sv
// ============================================================================
// hsvc_out_if: RGBA result channel
// Valid/ready handshake carrying one RGBA color per item.
// ============================================================================
`default_nettype none

interface hsvc_out_if;
  import hsvc_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  chan_t alpha;

  modport source (
    output valid, red, green, blue, alpha,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, alpha,
    output ready
  );
endinterface

`default_nettype wire

### rtl/hsvc_sector.sv
// ============================================================================
// hsvc_sector: hue wrap and sector split
// Two stages: sector count by reciprocal, then remainder and sector mod 6.
// ============================================================================
`default_nettype none

module hsvc_sector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hsvc_pkg::HUE_W-1:0]  in_hue,
  input  hsvc_pkg::chan_t                    in_sat,
  input  hsvc_pkg::chan_t                    in_bright,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hsvc_pkg::sect_t                    out_sect
);
  import hsvc_pkg::*;

  localparam int QP_W = HUE_Y_W + RCP15_W;
  localparam int SP_W = QUOT_W + RCP6_W;

  logic                 s1_en;
  logic                 s2_en;
  logic                 s1_valid_r;
  logic                 s2_valid_r;
  logic [HUE_X_W-1:0]   hue_x;
  logic [HUE_Y_W-1:0]   hue_y;
  logic [QP_W-1:0]      quot_prod;
  logic [QUOT_W-1:0]    quot_nxt;
  logic [HUE_X_W-1:0]   s1_x_r;
  logic [QUOT_W-1:0]    s1_quot_r;
  chan_t                s1_sat_r;
  chan_t                s1_bright_r;
  logic [HUE_X_W-1:0]   base;
  logic [HUE_X_W-1:0]   rem_full;
  logic [SP_W-1:0]      sec_prod;
  logic [QUOT_W-1:0]    turns6;
  logic [QUOT_W-1:0]    sec_idx;
  sect_t                sect_nxt;
  sect_t                out_sect_r;

  // Each stage moves when it is empty or its successor moves
  assign s2_en    = !s2_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  // Stage 1: bias by whole turns, count sectors: x/960 = (x>>6)/15
  assign hue_x     = HUE_X_W'({in_hue[HUE_W-1], in_hue}) + HUE_X_W'(HUE_BIAS);
  assign hue_y     = hue_x[HUE_X_W-1:SECT_SHIFT];
  assign quot_prod = {{RCP15_W{1'b0}}, hue_y} * QP_W'(RCP15);
  assign quot_nxt  = quot_prod[RCP15_SH +: QUOT_W];

  // Stage 2: remainder in the sector, sector count modulo six
  assign base     = {{(HUE_X_W-QUOT_W){1'b0}}, s1_quot_r} * HUE_X_W'(HUE_SECT);
  assign rem_full = s1_x_r - base;
  assign sec_prod = {{RCP6_W{1'b0}}, s1_quot_r} * SP_W'(RCP6);
  assign turns6   = QUOT_W'(sec_prod[SP_W-1:RCP6_SH]) * QUOT_W'(6);
  assign sec_idx  = s1_quot_r - turns6;

  always_comb begin
    sect_nxt.sector = sector_t'(sec_idx[2:0]);
    sect_nxt.rem    = rem_full[REM_W-1:0];
    sect_nxt.rem_c  = REM_W'(HUE_SECT) - rem_full[REM_W-1:0];
    sect_nxt.sat    = s1_sat_r;
    sect_nxt.bright = s1_bright_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_x_r      <= hue_x;
      s1_quot_r   <= quot_nxt;
      s1_sat_r    <= in_sat;
      s1_bright_r <= in_bright;
    end
    if (s2_en && s1_valid_r) begin
      out_sect_r <= sect_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_sect  = out_sect_r;

endmodule

`default_nettype wire

### rtl/hsvc_terms.sv
// ============================================================================
// hsvc_terms: p, q and t term pipeline
// Three stages: saturation products, brightness products, exact divides.
// ============================================================================
`default_nettype none

module hsvc_terms (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsvc_pkg::sect_t  in_sect,
  output logic             out_valid,
  input  logic             out_ready,
  output hsvc_pkg::terms_t out_terms
);
  import hsvc_pkg::*;

  localparam int SR_W  = CHAN_W + REM_W;
  localparam int ZQ_W  = Z_W + RCPD_W;
  localparam int PQ_W  = PP_W + RCPC_W;

  logic               s3_en;
  logic               s4_en;
  logic               s5_en;
  logic               s3_valid_r;
  logic               s4_valid_r;
  logic               s5_valid_r;

  logic [SR_W-1:0]    sq_prod;
  logic [SR_W-1:0]    st_prod;
  logic [NUM_W-1:0]   s3_num_q_r;
  logic [NUM_W-1:0]   s3_num_t_r;
  chan_t              s3_num_p_r;
  sector_t            s3_sector_r;
  chan_t              s3_bright_r;

  logic [PROD_W-1:0]  s4_prod_q_r;
  logic [PROD_W-1:0]  s4_prod_t_r;
  logic [PP_W-1:0]    s4_prod_p_r;
  sector_t            s4_sector_r;
  chan_t              s4_bright_r;

  logic [ZQ_W-1:0]    div_q;
  logic [ZQ_W-1:0]    div_t;
  logic [PQ_W-1:0]    div_p;
  terms_t             terms_nxt;
  terms_t             out_terms_r;

  assign s5_en    = !s5_valid_r || out_ready;
  assign s4_en    = !s4_valid_r || s5_en;
  assign s3_en    = !s3_valid_r || s4_en;
  assign in_ready = s3_en;

  // Stage 3: s*r and s*(SECT-r), folded into the numerators
  assign sq_prod = {{REM_W{1'b0}}, in_sect.sat} * {{CHAN_W{1'b0}}, in_sect.rem};
  assign st_prod = {{REM_W{1'b0}}, in_sect.sat} * {{CHAN_W{1'b0}}, in_sect.rem_c};

  // Stage 5: exact floors, DEN by shift then reciprocal, CMAX by reciprocal
  assign div_q = {{RCPD_W{1'b0}}, s4_prod_q_r[PROD_W-1:DEN_SHIFT]} * ZQ_W'(RCPD);
  assign div_t = {{RCPD_W{1'b0}}, s4_prod_t_r[PROD_W-1:DEN_SHIFT]} * ZQ_W'(RCPD);
  assign div_p = {{RCPC_W{1'b0}}, s4_prod_p_r} * PQ_W'(RCPC);

  always_comb begin
    terms_nxt.sector = s4_sector_r;
    terms_nxt.q      = div_q[RCPD_SH +: CHAN_W];
    terms_nxt.t      = div_t[RCPD_SH +: CHAN_W];
    terms_nxt.p      = div_p[RCPC_SH +: CHAN_W];
    terms_nxt.bright = s4_bright_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s3_en) s3_valid_r <= in_valid;
      if (s4_en) s4_valid_r <= s3_valid_r;
      if (s5_en) s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && in_valid) begin
      s3_num_q_r  <= NUM_W'(DEN) - NUM_W'(sq_prod);
      s3_num_t_r  <= NUM_W'(DEN) - NUM_W'(st_prod);
      s3_num_p_r  <= chan_t'(CMAX) - in_sect.sat;
      s3_sector_r <= in_sect.sector;
      s3_bright_r <= in_sect.bright;
    end
    if (s4_en && s3_valid_r) begin
      s4_prod_q_r <= {{NUM_W{1'b0}}, s3_bright_r} * {{CHAN_W{1'b0}}, s3_num_q_r};
      s4_prod_t_r <= {{NUM_W{1'b0}}, s3_bright_r} * {{CHAN_W{1'b0}}, s3_num_t_r};
      s4_prod_p_r <= {{CHAN_W{1'b0}}, s3_bright_r} * {{CHAN_W{1'b0}}, s3_num_p_r};
      s4_sector_r <= s3_sector_r;
      s4_bright_r <= s3_bright_r;
    end
    if (s5_en && s4_valid_r) begin
      out_terms_r <= terms_nxt;
    end
  end

  assign out_valid = s5_valid_r;
  assign out_terms = out_terms_r;

`ifndef ASSERT_OFF
  // No term exceeds the brightness it scales
  a_terms_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_terms.p <= out_terms.bright) && (out_terms.q <= out_terms.bright)
                  && (out_terms.t <= out_terms.bright))
    else $error("hsvc_terms: term above brightness");

  // p is the floor of the sector: q and t never fall below it
  a_terms_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_terms.q >= out_terms.p) && (out_terms.t >= out_terms.p))
    else $error("hsvc_terms: q or t below p");
`endif

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// ============================================================================
// hsv_to_rgb_converter: HSV to RGBA color conversion, one pixel per item
// Six-stage pipeline: hue wrap, sector split, terms, divides, channel select.
// ============================================================================
// Acceptance: the first of the six register stages loads at the accepting edge.
// Throughput: 1 item per cycle while the sink is ready; each of the six
//   register stages holds one item and moves whenever it is empty or its
//   successor moves.
// Reset: synchronous, active low; clears the stage valid bits only.
`default_nettype none

module hsv_to_rgb_converter (
  input  logic       clk,
  input  logic       rst_n,
  hsvc_in_if.sink    in_ch,
  hsvc_out_if.source out_ch
);
  import hsvc_pkg::*;

  // Handshake between the sector split and the term pipeline
  logic    sect_valid;
  logic    sect_ready;
  sect_t   sect;

  // Handshake between the term pipeline and the output stage
  logic    terms_valid;
  logic    terms_ready;
  terms_t  terms;

  // Output stage
  logic    out_en;
  logic    out_valid_r;
  chan_t   red_nxt;
  chan_t   green_nxt;
  chan_t   blue_nxt;
  chan_t   alpha_nxt;
  chan_t   red_r;
  chan_t   green_r;
  chan_t   blue_r;
  chan_t   alpha_r;

  // Stages 1-2: wrap the hue into one turn, split into sector and position
  hsvc_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_hue    (in_ch.hue_sixteenths),
    .in_sat    (in_ch.saturation),
    .in_bright (in_ch.brightness),
    .out_valid (sect_valid),
    .out_ready (sect_ready),
    .out_sect  (sect)
  );

  // Stages 3-5: exact floors of the p, q and t terms
  hsvc_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sect_valid),
    .in_ready  (sect_ready),
    .in_sect   (sect),
    .out_valid (terms_valid),
    .out_ready (terms_ready),
    .out_terms (terms)
  );

  // Stage 6: the output register. Load when empty or when the sink takes
  // the current item; this keeps the pipeline filling behind a waiting
  // result as long as any stage holds a bubble.
  assign out_en      = !out_valid_r || out_ch.ready;
  assign terms_ready = out_en;

  // Route v, p, q, t to the channels by sector. The dominant channel is the
  // brightness itself. Zero saturation needs no special arm: all terms then
  // equal the brightness. Zero brightness drives every term to zero.
  always_comb begin
    case (terms.sector)
      SEC_RY: begin
        red_nxt   = terms.bright;
        green_nxt = terms.t;
        blue_nxt  = terms.p;
      end
      SEC_YG: begin
        red_nxt   = terms.q;
        green_nxt = terms.bright;
        blue_nxt  = terms.p;
      end
      SEC_GC: begin
        red_nxt   = terms.p;
        green_nxt = terms.bright;
        blue_nxt  = terms.t;
      end
      SEC_CB: begin
        red_nxt   = terms.p;
        green_nxt = terms.q;
        blue_nxt  = terms.bright;
      end
      SEC_BM: begin
        red_nxt   = terms.t;
        green_nxt = terms.p;
        blue_nxt  = terms.bright;
      end
      default: begin
        red_nxt   = terms.bright;
        green_nxt = terms.p;
        blue_nxt  = terms.q;
      end
    endcase
  end

  // Alpha: opaque unless the brightness is zero
  assign alpha_nxt = (terms.bright != '0) ? chan_t'(CMAX) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= terms_valid;
    end
  end

  // Hold the payload while the sink stalls
  always_ff @(posedge clk) begin
    if (out_en && terms_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;
  assign out_ch.alpha = alpha_r;

`ifndef ASSERT_OFF
  // A transparent result is black in every channel
  a_alpha_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.alpha == '0) |->
      (out_ch.red == '0) && (out_ch.green == '0) && (out_ch.blue == '0))
    else $error("hsv_to_rgb_converter: zero alpha with a lit channel");

  // Alpha is only ever fully transparent or fully opaque
  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.alpha == '0) || (out_ch.alpha == chan_t'(CMAX)))
    else $error("hsv_to_rgb_converter: alpha neither 0 nor full scale");

  // With the output stage empty every stage can move, so input is open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("hsv_to_rgb_converter: input blocked with output empty");
`endif

endmodule

`default_nettype wire

### verif/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_hsv_to_rgb_converter: self-checking bench for the HSV to RGBA converter
// Drives HSV pixels through the valid/ready input channel with random gaps
// and stalls on the result channel. Predicts each RGBA result with exact
// integer arithmetic and checks the results in order, field by field.
// ============================================================================

module tb_hsv_to_rgb_converter;
  import hsvc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_PIXELS = 400;
  localparam int STALL_MAX     = 19;
  localparam int SETTLE_CYCLES = 20;     // pipeline is 6 deep, leave margin
  localparam int WATCHDOG_MAX  = 1000;   // cycles without any handshake
  localparam int REPORT_MAX    = 10;

  typedef logic signed [HUE_W-1:0] hue_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

  typedef struct packed {
    hue_t  hue;
    chan_t sat;
    chan_t bright;
    rgba_t color;
  } pixel_rec_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the color of each accepted pixel and holds the
  // predictions in arrival order until the matching result comes out.
  // --------------------------------------------------------------------------
  class rgba_scoreboard;
    pixel_rec_t pending_colors[$];
    int         error_count;
    int         result_count;

    function new();
      error_count  = 0;
      result_count = 0;
    endfunction

    // Exact six-sector conversion; every term is floored.
    function rgba_t convert_hsv(hue_t hue, chan_t sat, chan_t bright);
      int              wrapped;
      int unsigned     pos;
      longint unsigned v, s, den, p, q, t;
      sector_t         sector;
      rgba_t           px;
      wrapped = int'(hue) % HUE_FULL;
      if (wrapped < 0) wrapped += HUE_FULL;
      v  = bright;
      s  = sat;
      px = '0;
      px.alpha = chan_t'(CMAX);
      if (v == 0) begin
        px.alpha = '0;
      end else if (s == 0) begin
        px.red   = bright;
        px.green = bright;
        px.blue  = bright;
      end else begin
        sector = sector_t'(wrapped / HUE_SECT);
        pos    = wrapped % HUE_SECT;
        den    = CMAX * HUE_SECT;
        p = (v * (CMAX - s)) / CMAX;
        q = (v * (den - s * pos)) / den;
        t = (v * (den - s * (HUE_SECT - pos))) / den;
        case (sector)
          SEC_RY: px[31:8] = {bright,    t[7:0],    p[7:0]};
          SEC_YG: px[31:8] = {q[7:0],    bright,    p[7:0]};
          SEC_GC: px[31:8] = {p[7:0],    bright,    t[7:0]};
          SEC_CB: px[31:8] = {p[7:0],    q[7:0],    bright};
          SEC_BM: px[31:8] = {t[7:0],    p[7:0],    bright};
          default: px[31:8] = {bright,   p[7:0],    q[7:0]};
        endcase
      end
      return px;
    endfunction

    function void note_pixel(hue_t hue, chan_t sat, chan_t bright);
      pixel_rec_t rec;
      rec.hue    = hue;
      rec.sat    = sat;
      rec.bright = bright;
      rec.color  = convert_hsv(hue, sat, bright);
      pending_colors.push_back(rec);
    endfunction

    function void check_pixel(rgba_t got);
      pixel_rec_t rec;
      result_count++;
      if (pending_colors.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("[%0t] unexpected result %0d: rgba=%0d/%0d/%0d/%0d", $time,
                   result_count, got.red, got.green, got.blue, got.alpha);
        return;
      end
      rec = pending_colors.pop_front();
      if (got.red !== rec.color.red || got.green !== rec.color.green ||
          got.blue !== rec.color.blue || got.alpha !== rec.color.alpha) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("[%0t] result %0d hue=%0d s=%0d v=%0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   $time, result_count, rec.hue, rec.sat, rec.bright,
                   rec.color.red, rec.color.green, rec.color.blue, rec.color.alpha,
                   got.red, got.green, got.blue, got.alpha);
      end
    endfunction

    function int pending();
      return pending_colors.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block under test
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  hsvc_in_if  in_ch ();
  hsvc_out_if out_ch ();

  hsv_to_rgb_converter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  rgba_scoreboard sb = new();

  // Fast modes give stretches with no gaps or stalls at all.
  bit send_fast;
  bit recv_fast;
  int idle_cycles;

  // --------------------------------------------------------------------------
  // Sender: wait a drawn number of cycles with valid low, then present the
  // item at a falling edge and hold it until a rising edge sees ready.
  // --------------------------------------------------------------------------
  task automatic send_hsv(input hue_t hue, input chan_t sat, input chan_t bright);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, STALL_MAX);
    if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.hue_sixteenths <= hue;
    in_ch.saturation     <= sat;
    in_ch.brightness     <= bright;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(hue, sat, bright);
  endtask

  // Drop valid and hold off until every predicted color has come out.
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall a drawn number of cycles, then raise ready and take one
  // result at the next rising edge where valid is high.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int    stall;
    rgba_t got;
    out_ch.ready = 1'b0;
    recv_fast    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = recv_fast ? 0 : $urandom_range(0, STALL_MAX);
      if ($urandom_range(0, 39) == 0) recv_fast = !recv_fast;
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha};
      sb.check_pixel(got);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no handshake on either channel.
  // --------------------------------------------------------------------------
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_MAX);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int    kind;
    int    hue_val;
    hue_t  hue;
    chan_t sat;
    chan_t bright;

    clk                  = 1'b0;
    rst_n                = 1'b0;
    send_fast            = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.hue_sixteenths = '0;
    in_ch.saturation     = '0;
    in_ch.brightness     = '0;

    // Hold reset for a fixed number of cycles, release it at a falling edge.
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all sector starts, ends of sectors 0 and 5, wrap of large and
    // negative hues, hue extremes, gray and black, exact halfway fractions.
    send_hsv(16'sd0,      8'd255, 8'd255);
    send_hsv(16'sd960,    8'd255, 8'd255);
    send_hsv(16'sd1920,   8'd255, 8'd255);
    send_hsv(16'sd2880,   8'd255, 8'd255);
    send_hsv(16'sd3840,   8'd255, 8'd255);
    send_hsv(16'sd4800,   8'd255, 8'd255);
    send_hsv(16'sd959,    8'd255, 8'd255);
    send_hsv(16'sd5759,   8'd255, 8'd255);
    send_hsv(16'sd5760,   8'd255, 8'd255);
    send_hsv(-16'sd1,     8'd255, 8'd255);
    send_hsv(-16'sd5760,  8'd255, 8'd255);
    send_hsv(-16'sd960,   8'd10,  8'd255);
    send_hsv(-16'sd32768, 8'd255, 8'd255);
    send_hsv(16'sd32767,  8'd255, 8'd255);
    send_hsv(-16'sd32768, 8'd255, 8'd0);
    send_hsv(16'sd100,    8'd0,   8'd200);
    send_hsv(16'sd32767,  8'd0,   8'd255);
    send_hsv(16'sd100,    8'd0,   8'd0);
    send_hsv(16'sd480,    8'd255, 8'd255);
    send_hsv(16'sd1440,   8'd255, 8'd128);
    send_hsv(16'sd2000,   8'd128, 8'd1);
    send_hsv(16'sd3000,   8'd1,   8'd255);
    send_hsv(16'sd4321,   8'd200, 8'd77);

    // Let the pipeline empty completely before the random part.
    hold_until_drained();

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      kind    = $urandom_range(0, 9);
      hue_val = $urandom_range(0, 65535);
      sat     = chan_t'($urandom_range(0, 255));
      bright  = chan_t'($urandom_range(0, 255));
      case (kind)
        4, 5: begin
          // Land on or next to a sector border, a few turns away from zero.
          hue_val = $urandom_range(0, 5) * HUE_SECT + $urandom_range(0, 2) - 1
                    + (int'($urandom_range(0, 9)) - 5) * HUE_FULL;
        end
        6: begin
          // Push saturation or brightness to the ends of their range.
          case ($urandom_range(0, 3))
            0: sat    = '0;
            1: sat    = chan_t'(CMAX);
            2: bright = chan_t'($urandom_range(0, 1));
            default: bright = chan_t'(CMAX - $urandom_range(0, 1));
          endcase
        end
        7: sat = chan_t'(CMAX);
        8: hue_val = -int'($urandom_range(1, 32768));
        default: ;
      endcase
      hue = hue_t'(hue_val);
      send_hsv(hue, sat, bright);
      // Pause once mid-run until every outstanding color has come back.
      if (n == RANDOM_PIXELS / 2) hold_until_drained();
    end

    // Drop valid, drain, and watch a few more cycles for stray results.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
